FILE: rtl/lkv_pkg.sv
// shared types and constants for the lru key-value cache
`timescale 1ns / 1ps
package lkv_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] OP_SET = 2'd0;
    localparam logic [1:0] OP_GET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    localparam logic [2:0] ST_SET_UPD   = 3'd0;
    localparam logic [2:0] ST_SET_INS   = 3'd1;
    localparam logic [2:0] ST_SET_EVICT = 3'd2;
    localparam logic [2:0] ST_GET_HIT   = 3'd3;
    localparam logic [2:0] ST_GET_MISS  = 3'd4;
    localparam logic [2:0] ST_DEL       = 3'd5;

    typedef enum logic [0:0] {
        MODE_FRONT = 1'b0,
        MODE_CLOSE = 1'b1
    } t_mode;

    typedef struct packed {
        logic  active;
        t_mode mode;
        logic  use_tail;
    } t_cell_cmd;

endpackage

FILE: rtl/lkv_cell.sv
// one entry of the recency-ordered cell row
`timescale 1ns / 1ps
module lkv_cell #(
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lkv_pkg::t_cell_cmd    i_cmd,
    input  logic [KEY_BITS-1:0]   i_req_key,
    input  logic                  i_prev_valid,
    input  logic [KEY_BITS-1:0]   i_prev_key,
    input  logic [VALUE_BITS-1:0] i_prev_value,
    input  logic                  i_prev_upto,
    input  logic                  i_next_valid,
    input  logic [KEY_BITS-1:0]   i_next_key,
    input  logic [VALUE_BITS-1:0] i_next_value,
    output logic                  o_valid,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_match,
    output logic                  o_upto
);
    import lkv_pkg::*;

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  w_tail;
    logic                  w_mark;
    logic                  w_take_prev;
    logic                  w_take_next;

    assign o_match = r_valid && (r_key == i_req_key);
    assign w_tail  = r_valid && !i_next_valid;
    assign w_mark  = i_cmd.use_tail ? w_tail : o_match;
    assign o_upto  = i_prev_upto | w_mark;

    assign w_take_prev = i_cmd.active && (i_cmd.mode == MODE_FRONT) && !i_prev_upto;
    assign w_take_next = i_cmd.active && (i_cmd.mode == MODE_CLOSE) && o_upto;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take_prev) begin
            r_valid <= i_prev_valid;
        end else if (w_take_next) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_prev) begin
            r_key   <= i_prev_key;
            r_value <= i_prev_value;
        end else if (w_take_next) begin
            r_key   <= i_next_key;
            r_value <= i_next_value;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_value = r_value;

endmodule

FILE: rtl/lru_key_value_cache_unit.sv
// lru key-value cache top level: request stage, cell row, result register
// path: the item enters the request register, then the cell row and result register update together
// throughput: one item per cycle while the result side does not stall
// the rate is set by the cell row: key compare, shift chain and entry move all happen in the same cycle
// reset: all cells invalid, occupancy zero, capacity 16, no item held
`timescale 1ns / 1ps
module lru_key_value_cache_unit #(
    parameter int ENTRIES    = lkv_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_op,
    input  logic [KEY_BITS-1:0]      i_key,
    input  logic [VALUE_BITS-1:0]    i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [2:0]               o_status,
    output logic                     o_found,
    output logic [VALUE_BITS-1:0]    o_read_value,
    output logic [KEY_BITS-1:0]      o_evicted_key,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0] i_cfg_data
);
    import lkv_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] ENTRIES_CMP = CMP_W'(ENTRIES);

    logic                  r_req_valid;
    logic [1:0]            r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [CAP_W-1:0]      r_cap;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic                  r_out_valid;
    logic [2:0]            r_status;
    logic                  r_found;
    logic [VALUE_BITS-1:0] r_read_value;
    logic [KEY_BITS-1:0]   r_evicted_key;
    logic [2:0]            n_status;
    logic                  n_found;
    logic [VALUE_BITS-1:0] n_read_value;
    logic [KEY_BITS-1:0]   n_evicted_key;

    logic                  w_out_free;
    logic                  w_accept;
    logic                  w_process;
    logic                  w_hit;
    logic                  w_evict;
    logic [CMP_W-1:0]      w_cap_lo;
    logic [CMP_W-1:0]      w_cap_eff;
    logic [VALUE_BITS-1:0] w_hit_value;
    logic [KEY_BITS-1:0]   w_tail_key;
    logic [VALUE_BITS-1:0] w_front_value;
    t_cell_cmd             w_cmd;

    logic [ENTRIES-1:0]    w_valid;
    logic [ENTRIES-1:0]    w_valid_next;
    logic [ENTRIES-1:0]    w_tail;
    logic [ENTRIES-1:0]    w_match;
    logic [ENTRIES-1:0]    w_upto;
    logic [KEY_BITS-1:0]   w_key   [ENTRIES];
    logic [VALUE_BITS-1:0] w_val   [ENTRIES];

    // handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_process  = r_req_valid && w_out_free;
    assign o_in_stall = r_req_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (w_accept) begin
            r_req_valid <= 1'b1;
        end else if (w_process) begin
            r_req_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // effective capacity and eviction decision
    assign w_cap_lo  = (r_cap == '0) ? CMP_W'(1) : CMP_W'(r_cap);
    assign w_cap_eff = (w_cap_lo > ENTRIES_CMP) ? ENTRIES_CMP : w_cap_lo;
    assign w_evict   = CMP_W'(r_count) >= w_cap_eff;

    // cell row, index 0 most recent
    assign w_valid_next = {1'b0, w_valid[ENTRIES-1:1]};
    assign w_tail       = w_valid & ~w_valid_next;
    assign w_hit        = |w_match;

    always_comb begin
        w_hit_value = '0;
        w_tail_key  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit_value = w_hit_value | w_val[i];
            end
            if (w_tail[i]) begin
                w_tail_key = w_tail_key | w_key[i];
            end
        end
    end

    assign w_front_value = (r_op == OP_GET) ? w_hit_value : r_value;

    always_comb begin
        w_cmd.active   = 1'b0;
        w_cmd.mode     = MODE_FRONT;
        w_cmd.use_tail = 1'b0;
        unique case (r_op)
            OP_SET: begin
                w_cmd.active   = w_process;
                w_cmd.use_tail = !w_hit && w_evict;
            end
            OP_GET: begin
                w_cmd.active = w_process && w_hit;
            end
            OP_DEL: begin
                w_cmd.active = w_process && w_hit;
                w_cmd.mode   = MODE_CLOSE;
            end
            default: begin
                w_cmd.active = 1'b0;
            end
        endcase
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        logic                  w_pv;
        logic [KEY_BITS-1:0]   w_pk;
        logic [VALUE_BITS-1:0] w_pval;
        logic                  w_pu;
        logic                  w_nv;
        logic [KEY_BITS-1:0]   w_nk;
        logic [VALUE_BITS-1:0] w_nval;

        if (g == 0) begin : g_head
            assign w_pv   = 1'b1;
            assign w_pk   = r_key;
            assign w_pval = w_front_value;
            assign w_pu   = 1'b0;
        end else begin : g_body
            assign w_pv   = w_valid[g-1];
            assign w_pk   = w_key[g-1];
            assign w_pval = w_val[g-1];
            assign w_pu   = w_upto[g-1];
        end

        if (g == ENTRIES - 1) begin : g_end
            assign w_nv   = 1'b0;
            assign w_nk   = '0;
            assign w_nval = '0;
        end else begin : g_mid
            assign w_nv   = w_valid[g+1];
            assign w_nk   = w_key[g+1];
            assign w_nval = w_val[g+1];
        end

        lkv_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_req_key    (r_key),
            .i_prev_valid (w_pv),
            .i_prev_key   (w_pk),
            .i_prev_value (w_pval),
            .i_prev_upto  (w_pu),
            .i_next_valid (w_nv),
            .i_next_key   (w_nk),
            .i_next_value (w_nval),
            .o_valid      (w_valid[g]),
            .o_key        (w_key[g]),
            .o_value      (w_val[g]),
            .o_match      (w_match[g]),
            .o_upto       (w_upto[g])
        );
    end

    // result and occupancy
    always_comb begin
        n_status      = ST_GET_MISS;
        n_found       = 1'b0;
        n_read_value  = '0;
        n_evicted_key = '0;
        n_count       = r_count;
        unique case (r_op)
            OP_SET: begin
                if (w_hit) begin
                    n_status = ST_SET_UPD;
                    n_found  = 1'b1;
                end else if (w_evict) begin
                    n_status      = ST_SET_EVICT;
                    n_evicted_key = w_tail_key;
                end else begin
                    n_status = ST_SET_INS;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_GET: begin
                if (w_hit) begin
                    n_status     = ST_GET_HIT;
                    n_found      = 1'b1;
                    n_read_value = w_hit_value;
                end
            end
            OP_DEL: begin
                n_status = ST_DEL;
                n_found  = w_hit;
                if (w_hit) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_status = ST_GET_MISS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_process) begin
                r_count <= n_count;
            end
            if (w_process) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_status      <= n_status;
            r_found       <= n_found;
            r_read_value  <= n_read_value;
            r_evicted_key <= n_evicted_key;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_read_value  = r_read_value;
    assign o_evicted_key = r_evicted_key;

    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_W'($countones(w_valid)))
        else $error("occupancy count differs from valid cells");

    a_cells_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid_next & ~w_valid) == '0)
        else $error("valid cells not packed toward the front");

    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid |-> $onehot0(w_match))
        else $error("key present in more than one cell");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= ENTRIES_CMP)
        else $error("occupancy above built size");

endmodule
